// ===== rtl/mccd_pkg.sv =====
package mccd_pkg;

    // field widths
    localparam int COIN_W   = 16;
    localparam int TARGET_W = 16;
    localparam int RESULT_W = 17;

    // default sizes
    localparam int MAX_COINS_DEF  = 128;
    localparam int MAX_TARGET_DEF = 65535;

    // largest target that the 16-bit field can carry
    localparam int TARGET_LIMIT = (1 << TARGET_W) - 1;

    // unreachable mark, also the -1 answer
    localparam logic [RESULT_W-1:0] UNREACHED = {RESULT_W{1'b1}};

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_COIN_RD,
        S_COIN_CHK,
        S_TAB_CHK,
        S_WRITE
    } t_state;

endpackage

// ===== rtl/min_coin_change_dp_core.sv =====
// minimum-coin change core
// command port: a transaction is taken on a rising edge with start high
// and busy low. i_action selects clear coin list, append i_coin_value
// (dropped once the list holds MAX_COINS coins) or query i_target.
// clear and append leave busy low; they give no result.
// a query of a target from 1 to MAX_TARGET raises busy and fills a table
// of best counts from 0 up to the target, one entry per row, walking the
// coin list for every entry. per row the sequencer reads each coin, checks
// it and, for a coin that is nonzero and not above the row index, reads the
// table entry below and keeps the smaller count; then it writes the row.
// the coin list has one read port and the table one port, registered reads.
// a target of 0 or above MAX_TARGET answers on the next cycle, busy low.
// the answer (o_min_coins, -1 when unreachable) shows for one cycle with
// o_valid high, in the cycle in which busy drops; the receiver cannot stall.
// reset empties the coin list and returns the sequencer to idle; the
// count table needs no clearing since every query writes before reading.
module min_coin_change_dp_core
    import mccd_pkg::*;
#(
    parameter int MAX_COINS  = MAX_COINS_DEF,
    parameter int MAX_TARGET = MAX_TARGET_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_action,
    input  logic [COIN_W-1:0]          i_coin_value,
    input  logic [TARGET_W-1:0]        i_target,
    output logic                       o_valid,
    output logic signed [RESULT_W-1:0] o_min_coins
);

    localparam int CNT_W     = $clog2(MAX_COINS + 1);
    localparam int CIDX_W    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
    localparam int TAB_DEPTH =
        ((MAX_TARGET < TARGET_LIMIT) ? MAX_TARGET : TARGET_LIMIT) + 1;
    localparam int TAB_AW    = $clog2(TAB_DEPTH);

    logic                w_clear;
    logic                w_append;
    logic [CIDX_W-1:0]   w_coin_addr;
    logic [COIN_W-1:0]   w_coin_data;
    logic [CNT_W-1:0]    w_coin_count;
    logic                w_tab_we;
    logic [TAB_AW-1:0]   w_tab_addr;
    logic [RESULT_W-1:0] w_tab_wdata;
    logic [RESULT_W-1:0] w_tab_rdata;
    logic [RESULT_W-1:0] w_result;

    // coin list and count
    mccd_coin_store #(
        .MAX_COINS (MAX_COINS)
    ) u_coins (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_append  (w_append),
        .i_value   (i_coin_value),
        .i_rd_addr (w_coin_addr),
        .o_rd_data (w_coin_data),
        .o_count   (w_coin_count)
    );

    // best count table
    mccd_table_ram #(
        .MAX_TARGET (MAX_TARGET)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_tab_we),
        .i_addr  (w_tab_addr),
        .i_wdata (w_tab_wdata),
        .o_rdata (w_tab_rdata)
    );

    // sequencer with the shared add and compare
    mccd_seq #(
        .MAX_COINS  (MAX_COINS),
        .MAX_TARGET (MAX_TARGET)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_action     (i_action),
        .i_target     (i_target),
        .i_coin_count (w_coin_count),
        .i_coin_data  (w_coin_data),
        .i_tab_data   (w_tab_rdata),
        .o_clear      (w_clear),
        .o_append     (w_append),
        .o_coin_addr  (w_coin_addr),
        .o_tab_we     (w_tab_we),
        .o_tab_addr   (w_tab_addr),
        .o_tab_wdata  (w_tab_wdata),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_result     (w_result)
    );

    assign o_min_coins = $signed(w_result);

endmodule

// ===== rtl/mccd_coin_store.sv =====
module mccd_coin_store
    import mccd_pkg::*;
#(
    parameter int MAX_COINS = MAX_COINS_DEF,
    localparam int CNT_W    = $clog2(MAX_COINS + 1),
    localparam int CIDX_W   = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_clear,
    input  logic              i_append,
    input  logic [COIN_W-1:0] i_value,
    input  logic [CIDX_W-1:0] i_rd_addr,
    output logic [COIN_W-1:0] o_rd_data,
    output logic [CNT_W-1:0]  o_count
);

    logic [COIN_W-1:0] r_mem [MAX_COINS];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_full;
    logic              w_we;

    assign w_full = (r_count == CNT_W'(MAX_COINS));
    assign w_we   = i_append && !w_full;

    // coin count
    always_comb begin
        n_count = r_count;
        if (i_clear) begin
            n_count = '0;
        end else if (w_we) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // coin list storage, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[CIDX_W-1:0]] <= i_value;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_count = r_count;

endmodule

// ===== rtl/mccd_table_ram.sv =====
module mccd_table_ram
    import mccd_pkg::*;
#(
    parameter int MAX_TARGET = MAX_TARGET_DEF,
    localparam int TAB_DEPTH =
        ((MAX_TARGET < TARGET_LIMIT) ? MAX_TARGET : TARGET_LIMIT) + 1,
    localparam int TAB_AW    = $clog2(TAB_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [TAB_AW-1:0]   i_addr,
    input  logic [RESULT_W-1:0] i_wdata,
    output logic [RESULT_W-1:0] o_rdata
);

    logic [RESULT_W-1:0] r_mem [TAB_DEPTH];

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== rtl/mccd_seq.sv =====
module mccd_seq
    import mccd_pkg::*;
#(
    parameter int MAX_COINS  = MAX_COINS_DEF,
    parameter int MAX_TARGET = MAX_TARGET_DEF,
    localparam int CNT_W     = $clog2(MAX_COINS + 1),
    localparam int CIDX_W    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1,
    localparam int TAB_DEPTH =
        ((MAX_TARGET < TARGET_LIMIT) ? MAX_TARGET : TARGET_LIMIT) + 1,
    localparam int TAB_AW    = $clog2(TAB_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_action,
    input  logic [TARGET_W-1:0] i_target,
    input  logic [CNT_W-1:0]    i_coin_count,
    input  logic [COIN_W-1:0]   i_coin_data,
    input  logic [RESULT_W-1:0] i_tab_data,
    output logic                o_clear,
    output logic                o_append,
    output logic [CIDX_W-1:0]   o_coin_addr,
    output logic                o_tab_we,
    output logic [TAB_AW-1:0]   o_tab_addr,
    output logic [RESULT_W-1:0] o_tab_wdata,
    output logic                o_busy,
    output logic                o_valid,
    output logic [RESULT_W-1:0] o_result
);

    t_state              r_state, n_state;
    logic [TARGET_W-1:0] r_goal, n_goal;
    logic [TARGET_W-1:0] r_i, n_i;
    logic [CIDX_W-1:0]   r_j, n_j;
    logic [RESULT_W-1:0] r_best, n_best;
    logic                r_valid, n_valid;
    logic [RESULT_W-1:0] r_result, n_result;

    logic                w_accept;
    logic                w_last_coin;
    logic                w_coin_fits;
    logic [TARGET_W-1:0] w_below;
    logic [RESULT_W-1:0] w_cand;
    logic                w_over;

    assign w_accept    = i_start && (r_state == S_IDLE);
    assign w_last_coin = ((CNT_W'(r_j) + CNT_W'(1)) == i_coin_count);
    assign w_coin_fits = (i_coin_data != '0) && (i_coin_data <= r_i);
    assign w_below     = r_i - i_coin_data;
    assign w_cand      = i_tab_data + RESULT_W'(1);
    assign w_over      = (32'(i_target) > 32'(MAX_TARGET));

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_goal   = r_goal;
        n_i      = r_i;
        n_j      = r_j;
        n_best   = r_best;
        n_valid  = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (t_action'(i_action) == ACT_QUERY)) begin
                    n_goal = i_target;
                    if (w_over) begin
                        n_valid  = 1'b1;
                        n_result = UNREACHED;
                    end else if (i_target == '0) begin
                        n_valid  = 1'b1;
                        n_result = '0;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                n_i     = TARGET_W'(1);
                n_state = S_ROW;
            end
            S_ROW: begin
                n_best  = UNREACHED;
                n_j     = '0;
                n_state = (i_coin_count == '0) ? S_WRITE : S_COIN_RD;
            end
            S_COIN_RD: begin
                n_state = S_COIN_CHK;
            end
            S_COIN_CHK: begin
                if (w_coin_fits) begin
                    n_state = S_TAB_CHK;
                end else if (w_last_coin) begin
                    n_state = S_WRITE;
                end else begin
                    n_j     = r_j + CIDX_W'(1);
                    n_state = S_COIN_RD;
                end
            end
            S_TAB_CHK: begin
                // shared compare: keep the smaller count
                if ((i_tab_data != UNREACHED) && (w_cand < r_best)) begin
                    n_best = w_cand;
                end
                if (w_last_coin) begin
                    n_state = S_WRITE;
                end else begin
                    n_j     = r_j + CIDX_W'(1);
                    n_state = S_COIN_RD;
                end
            end
            S_WRITE: begin
                if (r_i == r_goal) begin
                    n_valid  = 1'b1;
                    n_result = r_best;
                    n_state  = S_IDLE;
                end else begin
                    n_i     = r_i + TARGET_W'(1);
                    n_state = S_ROW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory controls and handshake
    always_comb begin
        o_clear     = 1'b0;
        o_append    = 1'b0;
        o_coin_addr = r_j;
        o_tab_we    = 1'b0;
        o_tab_addr  = r_i[TAB_AW-1:0];
        o_tab_wdata = r_best;
        o_busy      = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_clear  = (t_action'(i_action) == ACT_CLEAR);
                    o_append = (t_action'(i_action) == ACT_APPEND);
                end
            end
            S_INIT: begin
                o_tab_we    = 1'b1;
                o_tab_addr  = '0;
                o_tab_wdata = '0;
            end
            S_COIN_CHK: begin
                o_tab_addr = w_below[TAB_AW-1:0];
            end
            S_WRITE: begin
                o_tab_we = 1'b1;
            end
            default: begin
                o_tab_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_goal   <= n_goal;
        r_i      <= n_i;
        r_j      <= n_j;
        r_best   <= n_best;
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sim/min_coin_change_dp_core_tb.sv =====
module min_coin_change_dp_core_tb
    import mccd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // the one action code the block leaves unused
    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int ITEM_GOAL = 850;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [1:0]                 i_action = ACT_CLEAR;
    logic [COIN_W-1:0]          i_coin_value = '0;
    logic [TARGET_W-1:0]        i_target = '0;
    logic                       o_valid;
    logic signed [RESULT_W-1:0] o_min_coins;

    min_coin_change_dp_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_coin_value (i_coin_value),
        .i_target     (i_target),
        .o_valid      (o_valid),
        .o_min_coins  (o_min_coins)
    );

    // clock, 10 ns period
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the coin list and the count table
    logic [COIN_W-1:0]   coin_list [MAX_COINS_DEF];
    int unsigned         listed = 0;
    logic [RESULT_W-1:0] best_tab [0:MAX_TARGET_DEF];

    // answers still owed by the block, oldest first
    logic [RESULT_W-1:0] answers_owed [$];

    int n_items     = 0;
    int n_checked   = 0;
    int n_unreached = 0;
    int n_dropped   = 0;
    int n_errors    = 0;

    // directed stimulus; typed answers only where obvious
    typedef struct packed {
        logic [1:0]          act;
        logic [COIN_W-1:0]   coin;
        logic [TARGET_W-1:0] tgt;
        logic                typed;
        logic [RESULT_W-1:0] answer;
    } t_step_row;

    localparam int N_DIRECTED = 24;
    localparam t_step_row DIRECTED [N_DIRECTED] = '{
        '{ACT_QUERY,    16'h0000, 16'd0,     1'b1, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd5,     1'b1, UNREACHED},
        '{ACT_QUERY,    16'hFFFF, 16'hFFFF,  1'b1, UNREACHED},
        '{ACT_RESERVED, 16'hFFFF, 16'hFFFF,  1'b0, 17'd0},
        '{ACT_APPEND,   16'h0000, 16'h0000,  1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd7,     1'b1, UNREACHED},
        '{ACT_CLEAR,    16'hFFFF, 16'hFFFF,  1'b0, 17'd0},
        '{ACT_APPEND,   16'hFFFF, 16'h0000,  1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'hFFFF,  1'b1, 17'd1},
        '{ACT_CLEAR,    16'h0000, 16'h0000,  1'b0, 17'd0},
        '{ACT_APPEND,   16'd1,    16'h0000,  1'b0, 17'd0},
        '{ACT_APPEND,   16'd5,    16'h0000,  1'b0, 17'd0},
        '{ACT_APPEND,   16'd6,    16'h0000,  1'b0, 17'd0},
        '{ACT_APPEND,   16'd9,    16'h0000,  1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd11,    1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd13,    1'b0, 17'd0},
        '{ACT_APPEND,   16'h0000, 16'h0000,  1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd30,    1'b0, 17'd0},
        '{ACT_RESERVED, 16'h1234, 16'h0003,  1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd1,     1'b1, 17'd1},
        '{ACT_CLEAR,    16'h0000, 16'h0000,  1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd3,     1'b1, UNREACHED},
        '{ACT_APPEND,   16'd2,    16'h0000,  1'b0, 17'd0},
        '{ACT_QUERY,    16'h0000, 16'd8,     1'b1, 17'd4}
    };

    // fewest coins for a target, filling the shadow table from zero up
    function automatic logic [RESULT_W-1:0] fewest_coins(input int unsigned goal);
        int unsigned         row;
        int unsigned         k;
        logic [RESULT_W-1:0] best;
        logic [RESULT_W-1:0] below;
        best_tab[0] = '0;
        for (row = 1; row <= goal; row++) begin
            best = UNREACHED;
            for (k = 0; k < listed; k++) begin
                if (coin_list[k] != 0 && coin_list[k] <= row) begin
                    below = best_tab[row - coin_list[k]];
                    if (below != UNREACHED && below + 1 < best)
                        best = below + 1;
                end
            end
            best_tab[row] = best;
        end
        return best_tab[goal];
    endfunction

    // advance the shadow state by one transaction
    task automatic track_transaction(input logic [1:0] act, input logic [COIN_W-1:0] coin,
                                     input logic [TARGET_W-1:0] tgt,
                                     output bit answers, output logic [RESULT_W-1:0] answer);
        answers = 1'b0;
        answer  = '0;
        case (act)
            ACT_CLEAR: begin
                listed = 0;
            end
            ACT_APPEND: begin
                if (listed < MAX_COINS_DEF) begin
                    coin_list[listed] = coin;
                    listed++;
                end
            end
            ACT_QUERY: begin
                answers = 1'b1;
                if (tgt > MAX_TARGET_DEF)
                    answer = UNREACHED;
                else
                    answer = fewest_coins(tgt);
            end
            default: ;
        endcase
    endtask

    // drive one transaction and hold it until the block takes it
    task automatic issue(input logic [1:0] act, input logic [COIN_W-1:0] coin,
                         input logic [TARGET_W-1:0] tgt, input bit typed,
                         input logic [RESULT_W-1:0] typed_answer);
        bit                  answers;
        logic [RESULT_W-1:0] answer;
        start        <= 1'b1;
        i_action     <= act;
        i_coin_value <= coin;
        i_target     <= tgt;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        if (act == ACT_APPEND && listed >= MAX_COINS_DEF)
            n_dropped++;
        else if (act != ACT_RESERVED)
            n_items++;
        track_transaction(act, coin, tgt, answers, answer);
        if (answers)
            answers_owed.push_back(typed ? typed_answer : answer);
    endtask

    // sender gap; start only drops when the gap is not empty
    task automatic pause(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic int rand_gap(input bit calm);
        int r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [COIN_W-1:0] rand_coin();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return '0;
        if (r < 80)
            return COIN_W'($urandom_range(12, 1));
        if (r < 92)
            return COIN_W'($urandom_range(100, 13));
        return COIN_W'($urandom_range(65535));
    endfunction

    // targets stay small so the table walk stays short; big lists get tiny ones
    function automatic logic [TARGET_W-1:0] rand_target();
        int r;
        r = $urandom_range(99);
        if (listed > 16)
            return TARGET_W'($urandom_range(30));
        if (r < 75)
            return TARGET_W'($urandom_range(40));
        if (r < 95)
            return TARGET_W'($urandom_range(200));
        return TARGET_W'($urandom_range(1000));
    endfunction

    // result checker; the receiver never stalls
    logic [RESULT_W-1:0] owed;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (answers_owed.size() == 0) begin
                $display("%0t: unexpected answer %0d", $time, o_min_coins);
                n_errors++;
            end else begin
                owed = answers_owed.pop_front();
                n_checked++;
                if (owed == UNREACHED)
                    n_unreached++;
                if (o_min_coins !== owed) begin
                    $display("%0t: min_coins expected %0d got %0d", $time,
                             $signed(owed), o_min_coins);
                    n_errors++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int  seq;
        int  n_coins;
        int  n_queries;
        int  r;
        int  k;
        bit  calm;
        logic [1:0] act;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        for (k = 0; k < N_DIRECTED; k++) begin
            issue(DIRECTED[k].act, DIRECTED[k].coin, DIRECTED[k].tgt,
                  DIRECTED[k].typed, DIRECTED[k].answer);
            pause(rand_gap(1'b0));
        end

        // random sequences: clear, load a list, ask several targets
        seq = 0;
        while (n_items < ITEM_GOAL) begin
            calm = ($urandom_range(3) == 0);
            if (seq == 0 || $urandom_range(39) == 0) begin
                n_coins = MAX_COINS_DEF + $urandom_range(4, 1);
            end else begin
                r = $urandom_range(99);
                if (r < 5)
                    n_coins = 0;
                else if (r < 80)
                    n_coins = $urandom_range(6, 1);
                else
                    n_coins = $urandom_range(16, 7);
            end
            if (seq == 0 || $urandom_range(6) != 0) begin
                issue(ACT_CLEAR, COIN_W'($urandom), TARGET_W'($urandom), 1'b0, '0);
                pause(rand_gap(calm));
                for (k = 0; k < n_coins; k++) begin
                    issue(ACT_APPEND, rand_coin(), TARGET_W'($urandom), 1'b0, '0);
                    pause(rand_gap(calm));
                end
                n_queries = $urandom_range(6, 2);
                for (k = 0; k < n_queries; k++) begin
                    r = $urandom_range(19);
                    if (r == 0)
                        issue(ACT_RESERVED, COIN_W'($urandom), TARGET_W'($urandom), 1'b0, '0);
                    else if (r == 1)
                        issue(ACT_APPEND, rand_coin(), TARGET_W'($urandom), 1'b0, '0);
                    issue(ACT_QUERY, COIN_W'($urandom), rand_target(), 1'b0, '0);
                    pause(rand_gap(calm));
                end
            end else begin
                // noise: any action, any order
                repeat ($urandom_range(12, 4)) begin
                    act = 2'($urandom_range(3));
                    issue(act, rand_coin(),
                          (act == ACT_QUERY) ? rand_target() : TARGET_W'($urandom), 1'b0, '0);
                    pause(rand_gap(calm));
                end
            end
            seq++;
        end
        start <= 1'b0;

        // drain
        while (answers_owed.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("%0d transactions, %0d answers checked (%0d unreachable)",
                 n_items, n_checked, n_unreached);
        $display("%0d appends dropped on a full coin list", n_dropped);
        if (n_errors == 0 && answers_owed.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("%0t: timeout with %0d answers outstanding", $time, answers_owed.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== min_coin_change_dp_core.f =====
rtl/mccd_pkg.sv
rtl/mccd_coin_store.sv
rtl/mccd_table_ram.sv
rtl/mccd_seq.sv
rtl/min_coin_change_dp_core.sv
sim/min_coin_change_dp_core_tb.sv
